// ===== hw/rtl/arr_pkg.sv =====
// ----------------------------------------------------------------------------
// arr_pkg
// Shared types, constants and the control program of the aspect ratio reducer.
// ----------------------------------------------------------------------------
package arr_pkg;

  // Term widths
  localparam int TermW  = 31;
  localparam int ShiftW = 5;
  localparam int PcW    = 4;

  // Operations driven by one control word
  localparam logic [3:0] OpNop     = 4'd0;
  localparam logic [3:0] OpLoad    = 4'd1;
  localparam logic [3:0] OpGcdStep = 4'd2;
  localparam logic [3:0] OpGcdDone = 4'd3;
  localparam logic [3:0] OpDivStep = 4'd4;
  localparam logic [3:0] OpSaveNum = 4'd5;
  localparam logic [3:0] OpSaveDen = 4'd6;
  localparam logic [3:0] OpDefault = 4'd7;
  localparam logic [3:0] OpEmit    = 4'd8;

  // Jump conditions: jump to target when true, else fall through
  localparam logic [2:0] CondNever   = 3'd0;
  localparam logic [2:0] CondAlways  = 3'd1;
  localparam logic [2:0] CondNoInput = 3'd2;
  localparam logic [2:0] CondNotPos  = 3'd3;
  localparam logic [2:0] CondGcdBusy = 3'd4;
  localparam logic [2:0] CondDivBusy = 3'd5;
  localparam logic [2:0] CondOutBusy = 3'd6;

  // Program addresses
  localparam logic [PcW-1:0] PcIdle    = 4'd0;
  localparam logic [PcW-1:0] PcCheck   = 4'd1;
  localparam logic [PcW-1:0] PcGcd     = 4'd2;
  localparam logic [PcW-1:0] PcGcdDone = 4'd3;
  localparam logic [PcW-1:0] PcDivW    = 4'd4;
  localparam logic [PcW-1:0] PcSaveNum = 4'd5;
  localparam logic [PcW-1:0] PcDivH    = 4'd6;
  localparam logic [PcW-1:0] PcSaveDen = 4'd7;
  localparam logic [PcW-1:0] PcDefault = 4'd8;
  localparam logic [PcW-1:0] PcEmit    = 4'd9;

  // Last divider iteration (one quotient bit per step)
  localparam logic [ShiftW-1:0] DivLast = ShiftW'(TermW - 1);

  // Default and customary ratios
  localparam logic [TermW-1:0] DefNum   = 31'd16;
  localparam logic [TermW-1:0] DefDen   = 31'd9;
  localparam logic [TermW-1:0] WideNum  = 31'd8;
  localparam logic [TermW-1:0] WideDen  = 31'd5;
  localparam logic [TermW-1:0] WideNumN = 31'd16;
  localparam logic [TermW-1:0] WideDenN = 31'd10;
  localparam logic [TermW-1:0] CineNum  = 31'd64;
  localparam logic [TermW-1:0] CineDen  = 31'd27;
  localparam logic [TermW-1:0] CineNumN = 31'd21;
  localparam logic [TermW-1:0] CineDenN = 31'd9;

  typedef struct packed {
    logic [3:0]     op;
    logic [2:0]     cond;
    logic [PcW-1:0] target;
  } ctrl_word_t;

  // Control store
  function automatic ctrl_word_t rom_word(input logic [PcW-1:0] pc);
    ctrl_word_t cw;
    case (pc)
      PcIdle:    cw = '{op: OpLoad,    cond: CondNoInput, target: PcIdle};
      PcCheck:   cw = '{op: OpNop,     cond: CondNotPos,  target: PcDefault};
      PcGcd:     cw = '{op: OpGcdStep, cond: CondGcdBusy, target: PcGcd};
      PcGcdDone: cw = '{op: OpGcdDone, cond: CondNever,   target: PcIdle};
      PcDivW:    cw = '{op: OpDivStep, cond: CondDivBusy, target: PcDivW};
      PcSaveNum: cw = '{op: OpSaveNum, cond: CondNever,   target: PcIdle};
      PcDivH:    cw = '{op: OpDivStep, cond: CondDivBusy, target: PcDivH};
      PcSaveDen: cw = '{op: OpSaveDen, cond: CondAlways,  target: PcEmit};
      PcDefault: cw = '{op: OpDefault, cond: CondNever,   target: PcIdle};
      PcEmit:    cw = '{op: OpEmit,    cond: CondOutBusy, target: PcEmit};
      default:   cw = '{op: OpNop,     cond: CondAlways,  target: PcIdle};
    endcase
    return cw;
  endfunction

endpackage

// ===== hw/rtl/aspect_ratio_reducer.sv =====
// ----------------------------------------------------------------------------
// aspect_ratio_reducer
// Reduces a signed width/height pair to its aspect ratio in lowest terms.
// ----------------------------------------------------------------------------
// Input channel: frame_width/frame_height with in_valid/in_ready. Output
// channel: ratio_numerator/ratio_denominator with out_valid/out_ready.
// Each input item gives exactly one result item.
// If either side is zero or negative the result is 16:9. Otherwise both sides
// are divided by their greatest common divisor; 8:5 is reported as 16:10 and
// 64:27 as 21:9.
// One item is worked at a time under a microcoded sequencer. The GCD is a
// binary (subtract and shift) loop of one step per cycle; the two quotients
// come from one shared restoring divider at one bit per cycle. After its
// emit step the sequencer passes through an unused control word back to
// idle, where it takes the next item.
// A finished result sits in the output register; the block takes the next
// item while it waits. When the receiver stalls and a second result is
// ready, the sequencer holds at its emit step until the register frees.
// Reset (rst, synchronous) returns the sequencer to idle and drops out_valid.
module aspect_ratio_reducer (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic signed [31:0]             frame_width,
  input  logic signed [31:0]             frame_height,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [arr_pkg::TermW-1:0]      ratio_numerator,
  output logic [arr_pkg::TermW-1:0]      ratio_denominator
);

  localparam int W = arr_pkg::TermW;

  // Sequencer state
  logic [arr_pkg::PcW-1:0]    pc;
  logic [arr_pkg::PcW-1:0]    pc_next;
  arr_pkg::ctrl_word_t        cw;
  logic                       jump;

  // Datapath registers
  logic [W-1:0]               w;
  logic [W-1:0]               h;
  logic                       both_pos;
  logic [W-1:0]               a;
  logic [W-1:0]               b;
  logic [arr_pkg::ShiftW-1:0] k;
  logic [W-1:0]               g;
  logic [W-1:0]               rem;
  logic [W-1:0]               quo;
  logic [arr_pkg::ShiftW-1:0] cnt;
  logic [W-1:0]               num;

  // Combinational helpers
  logic                       accept;
  logic                       out_free;
  logic                       w_pos;
  logic                       h_pos;
  logic                       a_gt_b;
  logic [W-1:0]               diff_ab;
  logic [W-1:0]               diff_ba;
  logic [W:0]                 rem_sh;
  logic [W+1:0]               div_diff;
  logic                       div_ge;
  logic [W-1:0]               num_fix;
  logic [W-1:0]               den_fix;

  assign cw       = arr_pkg::rom_word(pc);
  assign in_ready = (pc == arr_pkg::PcIdle);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  assign w_pos = !frame_width[31] && (frame_width != 32'sd0);
  assign h_pos = !frame_height[31] && (frame_height != 32'sd0);

  // Binary GCD step logic
  assign a_gt_b  = a > b;
  assign diff_ab = a - b;
  assign diff_ba = b - a;

  // Restoring divider step logic
  assign rem_sh   = {rem, quo[W-1]};
  assign div_diff = {1'b0, rem_sh} - {2'b00, g};
  assign div_ge   = !div_diff[W+1];

  // Customary names for two ratios; quo holds the reduced height here
  always_comb begin
    num_fix = num;
    den_fix = quo;
    if (num == arr_pkg::WideNum && quo == arr_pkg::WideDen) begin
      num_fix = arr_pkg::WideNumN;
      den_fix = arr_pkg::WideDenN;
    end else if (num == arr_pkg::CineNum && quo == arr_pkg::CineDen) begin
      num_fix = arr_pkg::CineNumN;
      den_fix = arr_pkg::CineDenN;
    end
  end

  // Jump condition and next step
  always_comb begin
    case (cw.cond)
      arr_pkg::CondNever:   jump = 1'b0;
      arr_pkg::CondAlways:  jump = 1'b1;
      arr_pkg::CondNoInput: jump = !accept;
      arr_pkg::CondNotPos:  jump = !both_pos;
      arr_pkg::CondGcdBusy: jump = (a != b);
      arr_pkg::CondDivBusy: jump = (cnt != arr_pkg::DivLast);
      arr_pkg::CondOutBusy: jump = !out_free;
      default:              jump = 1'b0;
    endcase
    pc_next = jump ? cw.target : pc + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= arr_pkg::PcIdle;
    end else begin
      pc <= pc_next;
    end
  end

  // Datapath driven by the control word
  always_ff @(posedge clk) begin
    case (cw.op)
      arr_pkg::OpLoad: begin
        w        <= frame_width[W-1:0];
        h        <= frame_height[W-1:0];
        a        <= frame_width[W-1:0];
        b        <= frame_height[W-1:0];
        k        <= '0;
        both_pos <= w_pos && h_pos;
      end
      arr_pkg::OpGcdStep: begin
        if (a != b) begin
          if (!a[0] && !b[0]) begin
            a <= a >> 1;
            b <= b >> 1;
            k <= k + 1'b1;
          end else if (!a[0]) begin
            a <= a >> 1;
          end else if (!b[0]) begin
            b <= b >> 1;
          end else if (a_gt_b) begin
            a <= diff_ab >> 1;
          end else begin
            b <= diff_ba >> 1;
          end
        end
      end
      arr_pkg::OpGcdDone: begin
        g   <= a << k;
        rem <= '0;
        quo <= w;
        cnt <= '0;
      end
      arr_pkg::OpDivStep: begin
        rem <= div_ge ? div_diff[W-1:0] : rem_sh[W-1:0];
        quo <= {quo[W-2:0], div_ge};
        cnt <= cnt + 1'b1;
      end
      arr_pkg::OpSaveNum: begin
        num <= quo;
        rem <= '0;
        quo <= h;
        cnt <= '0;
      end
      // Stage the result in num/quo until the output register frees
      arr_pkg::OpSaveDen: begin
        num <= num_fix;
        quo <= den_fix;
      end
      arr_pkg::OpDefault: begin
        num <= arr_pkg::DefNum;
        quo <= arr_pkg::DefDen;
      end
      arr_pkg::OpEmit: begin
        if (out_free) begin
          ratio_numerator   <= num;
          ratio_denominator <= quo;
        end
      end
      default: begin
      end
    endcase
  end

  // Output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cw.op == arr_pkg::OpEmit && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

// ===== hw/rtl/arr_checker.sv =====
// ----------------------------------------------------------------------------
// arr_checker
// Port-level checks of the aspect ratio reducer, bound to the top level.
// ----------------------------------------------------------------------------
module arr_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [arr_pkg::TermW-1:0] ratio_numerator,
  input logic [arr_pkg::TermW-1:0] ratio_denominator
);

  // One item at a time: no accept right after an accept
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while an item is in flight");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(ratio_numerator)
      && $stable(ratio_denominator))
    else $error("stalled result changed");

  // Reduced terms are never zero
  a_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ratio_numerator != '0 && ratio_denominator != '0)
    else $error("zero term in result");

  // A new result appears only from the emit step, never from idle
  a_emit_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared while idle");

  // Reset drops the result
  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("out_valid after reset");

endmodule

bind aspect_ratio_reducer arr_checker u_arr_checker (
  .clk               (clk),
  .rst               (rst),
  .in_valid          (in_valid),
  .in_ready          (in_ready),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .ratio_numerator   (ratio_numerator),
  .ratio_denominator (ratio_denominator)
);
